@@ hw/rtl/tvma_pkg.sv @@
// ----------------------------------------------------------------------------
// Thermocouple averaging package
// Shared widths, register indexes, limits and control types for the
// validated moving-average filter.
// ----------------------------------------------------------------------------
package tvma_pkg;

  localparam int READING_W = 12;
  localparam int OFFSET_W  = 10;
  localparam int MAXV_W    = 12;
  localparam int SAMPLE_W  = 13;
  localparam int TEMP_W    = 11;

  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAL_OFFSET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_VALID  = 1'd1;

  localparam logic [MAXV_W-1:0]   MAX_VALID_RESET  = 12'd2000;
  localparam logic [OFFSET_W-1:0] CAL_OFFSET_RESET = 10'd0;

  // Largest calibrated sample that can be stored.
  localparam int SAMPLE_MAX = 4095;
  // Mean limits: positive magnitude limit and negative magnitude limit.
  localparam int TEMP_POS_LIMIT = 1023;
  localparam int TEMP_NEG_LIMIT = 1024;

  localparam int DEFAULT_WINDOW_DEPTH = 8;
  localparam int DEFAULT_DIV_NUM_W    = 17;
  localparam int DEFAULT_DIV_DEN_W    = 7;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ hw/rtl/tvma_in_if.sv @@
// ----------------------------------------------------------------------------
// Thermocouple reading channel
// Valid/ready channel carrying one raw reading and its fault flag.
// ----------------------------------------------------------------------------
interface tvma_in_if;
  import tvma_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [READING_W-1:0] reading;
  logic                 reading_fault;

  modport source (output valid, reading, reading_fault, input ready);
  modport sink   (input valid, reading, reading_fault, output ready);

endinterface

@@ hw/rtl/tvma_out_if.sv @@
// ----------------------------------------------------------------------------
// Averaged temperature channel
// Valid/ready channel carrying the averaged temperature and acceptance flag.
// ----------------------------------------------------------------------------
interface tvma_out_if;
  import tvma_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;
  logic                     sample_accepted;

  modport source (output valid, temperature, sample_accepted, input ready);
  modport sink   (input valid, temperature, sample_accepted, output ready);

endinterface

@@ hw/rtl/tvma_div.sv @@
// ----------------------------------------------------------------------------
// Bit-serial restoring divider
// Unsigned divide that shifts in one numerator bit and produces one
// quotient bit per cycle; done pulses as the last quotient bit is registered.
// ----------------------------------------------------------------------------
module tvma_div #(
  parameter int NUM_W = tvma_pkg::DEFAULT_DIV_NUM_W,
  parameter int DEN_W = tvma_pkg::DEFAULT_DIV_DEN_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tvma_pkg::div_ctrl_t ctrl,
  input  logic [NUM_W-1:0]  numerator,
  input  logic [DEN_W-1:0]  denominator,
  output logic [NUM_W-1:0]  quotient,
  output tvma_pkg::div_stat_t stat
);
  import tvma_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  num_sh_r;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W-1:0]  rem_r;
  logic [NUM_W-1:0]  quo_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;

  logic [DEN_W:0]    trial;
  logic              q_bit;
  logic [DEN_W:0]    trial_diff;

  assign trial      = {rem_r, num_sh_r[NUM_W-1]};
  assign q_bit      = (trial >= {1'b0, den_r});
  assign trial_diff = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(NUM_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      num_sh_r <= numerator;
      den_r    <= denominator;
      rem_r    <= '0;
      quo_r    <= '0;
    end else if (busy_r) begin
      num_sh_r <= {num_sh_r[NUM_W-2:0], 1'b0};
      quo_r    <= {quo_r[NUM_W-2:0], q_bit};
      // For a nonzero divisor, the partial remainder always stays below it.
      rem_r    <= q_bit ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_W'(NUM_W))
    else $error("divider step count out of range");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !ctrl.start && step_r == STEP_W'(1)) |=> (done_r && !busy_r))
    else $error("divider did not finish after its last step");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still busy");

endmodule

@@ hw/rtl/thermocouple_validated_moving_average_core.sv @@
// ----------------------------------------------------------------------------
// Validated thermocouple moving average
// Range-checks raw readings, calibrates and averages them over a window.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one raw reading in quarter degrees and a fault flag.
//   A faulted, zero or over-limit reading is rejected: the word returned on
//   out_chan holds the last averaged temperature with sample_accepted low.
//   An accepted reading gets the calibration offset, replaces the oldest
//   window entry and returns the new mean in whole degrees, rounded half
//   away from zero. Every input word gives exactly one output word.
//   The cfg port writes the offset (index 0) and limit (index 1); the user
//   must write only while the block is idle; the block does not enforce it.
//   A rejected reading goes from the idle state through the done state to
//   the output register; an accepted one passes through the update, prep,
//   divide and done states, the divide state lasting until the bit-serial
//   divider has shifted through every numerator bit. One word is processed
//   at a time and the input reopens as the output register is loaded. A
//   result waits in the output register while the receiver stalls, and the
//   next reading is already taken in meanwhile.
//   Reset clears the count, sum, pointer, held temperature, state and valid.
// ----------------------------------------------------------------------------
module thermocouple_validated_moving_average_core #(
  parameter int WINDOW_DEPTH = tvma_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  tvma_in_if.sink                             in_chan,
  tvma_out_if.source                          out_chan,
  input  logic                                cfg_we,
  input  logic [tvma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tvma_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import tvma_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);
  localparam int NUM_W = SUM_W + 1;
  localparam int DEN_W = CNT_W + 3;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_UPDATE = 5'b00010,
    S_PREP   = 5'b00100,
    S_DIV    = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [OFFSET_W-1:0] cal_offset_r;
  logic [MAXV_W-1:0]          max_valid_r;

  logic signed [SAMPLE_W-1:0] ring_mem [WINDOW_DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [PTR_W-1:0]           wr_pos_r;
  logic [CNT_W-1:0]           count_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [TEMP_W-1:0]   held_r;
  logic                       neg_r;

  logic signed [TEMP_W-1:0]   res_temp_r;
  logic                       res_acc_r;
  logic signed [TEMP_W-1:0]   out_temp_r;
  logic                       out_acc_r;
  logic                       out_valid_r;

  logic                       in_fire;
  logic                       reject;
  logic signed [SAMPLE_W:0]   cal_sum;
  logic signed [SAMPLE_W-1:0] cal_sample;
  logic                       window_full;
  logic signed [SAMPLE_W-1:0] old_sample;
  logic [SUM_W-1:0]           sum_mag;
  logic [NUM_W-1:0]           numerator;
  logic [DEN_W-1:0]           denominator;
  logic [NUM_W-1:0]           quotient;
  logic signed [TEMP_W-1:0]   mean_temp;
  logic                       out_slot_free;
  div_ctrl_t                  div_ctrl;
  div_stat_t                  div_stat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_offset_r <= CAL_OFFSET_RESET;
      max_valid_r  <= MAX_VALID_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_CAL_OFFSET: cal_offset_r <= cfg_wdata[OFFSET_W-1:0];
        CFG_IDX_MAX_VALID:  max_valid_r  <= cfg_wdata[MAXV_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign reject = in_chan.reading_fault || (in_chan.reading == '0) ||
                  (in_chan.reading > max_valid_r);

  // The offset can only pull a positive reading down to about -511, so
  // only the upper limit needs saturation.
  assign cal_sum    = $signed({2'b00, in_chan.reading}) +
                      (SAMPLE_W+1)'(cal_offset_r);
  assign cal_sample = (cal_sum > (SAMPLE_W+1)'(SAMPLE_MAX)) ?
                      SAMPLE_W'(SAMPLE_MAX) : cal_sum[SAMPLE_W-1:0];

  // Until the window is full, the slot about to be replaced was never
  // written and counts as zero.
  assign window_full = (count_r == CNT_W'(WINDOW_DEPTH));
  assign old_sample  = window_full ? rd_data_r : '0;

  assign sum_mag     = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign numerator   = {sum_mag, 1'b0} + NUM_W'({count_r, 2'b00});
  assign denominator = {count_r, 3'b000};

  always_comb begin
    if (!neg_r) begin
      mean_temp = (quotient > NUM_W'(TEMP_POS_LIMIT)) ?
                  TEMP_W'(TEMP_POS_LIMIT) : quotient[TEMP_W-1:0];
    end else if (quotient > NUM_W'(TEMP_NEG_LIMIT)) begin
      mean_temp = TEMP_W'(-TEMP_NEG_LIMIT);
    end else begin
      mean_temp = TEMP_W'(-$signed({1'b0, quotient[TEMP_W-1:0]}));
    end
  end

  assign div_ctrl.start = (state_r == S_PREP);
  assign out_slot_free  = !out_valid_r || out_chan.ready;

  tvma_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (div_ctrl),
    .numerator   (numerator),
    .denominator (denominator),
    .quotient    (quotient),
    .stat        (div_stat)
  );

  // Window storage: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (state_r == S_UPDATE) begin
      ring_mem[wr_pos_r] <= sample_r;
    end
    rd_data_r <= ring_mem[wr_pos_r];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_fire) state_nxt = reject ? S_DONE : S_UPDATE;
      S_UPDATE: state_nxt = S_PREP;
      S_PREP:   state_nxt = S_DIV;
      S_DIV:    if (div_stat.done) state_nxt = S_DONE;
      S_DONE:   if (out_slot_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_pos_r    <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_UPDATE) begin
        sum_r    <= sum_r - SUM_W'(old_sample) + SUM_W'(sample_r);
        wr_pos_r <= (wr_pos_r == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wr_pos_r + 1'b1;
        if (!window_full) begin
          count_r <= count_r + 1'b1;
        end
      end
      if (state_r == S_DIV && div_stat.done) begin
        held_r <= mean_temp;
      end
      if (state_r == S_DONE && out_slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r   <= cal_sample;
      res_temp_r <= held_r;
      res_acc_r  <= 1'b0;
    end
    // The sum is final once the update step is done; its sign picks the
    // direction of the rounded mean.
    if (state_r == S_PREP) begin
      neg_r <= sum_r[SUM_W-1];
    end
    if (state_r == S_DIV && div_stat.done) begin
      res_temp_r <= mean_temp;
      res_acc_r  <= 1'b1;
    end
    if (state_r == S_DONE && out_slot_free) begin
      out_temp_r <= res_temp_r;
      out_acc_r  <= res_acc_r;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.temperature     = out_temp_r;
  assign out_chan.sample_accepted = out_acc_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(WINDOW_DEPTH))
    else $error("sample count above window depth");

  a_div_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_stat.done) |=> (state_r == S_DONE && res_acc_r))
    else $error("finished divide did not reach the output stage");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !div_stat.busy)
    else $error("new reading taken while the divider is busy");

  a_accepted_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_acc_r) |-> (count_r != '0))
    else $error("accepted result with an empty window");

  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && reject) |=> (state_r == S_DONE && !res_acc_r && $stable(sum_r)))
    else $error("rejected reading changed the average");

endmodule
